// ----- design/ael_pkg.sv -----
// Shared types, character codes and the per-step lexer rule.
package ael_pkg;

  // Character codes
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_E   = 8'h45;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_E   = 8'h65;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;

  typedef enum logic [4:0] {
    KIND_VAR      = 5'd0,
    KIND_INT      = 5'd1,
    KIND_REAL     = 5'd2,
    KIND_COMMENT  = 5'd3,
    KIND_PLUS     = 5'd4,
    KIND_MINUS    = 5'd5,
    KIND_STAR     = 5'd6,
    KIND_CARET    = 5'd7,
    KIND_LPAREN   = 5'd8,
    KIND_RPAREN   = 5'd9,
    KIND_EQUAL    = 5'd10,
    KIND_SLASH    = 5'd11,
    KIND_ERR_INIT = 5'd12,
    KIND_ERR_VAR  = 5'd13,
    KIND_ERR_INT  = 5'd14,
    KIND_ERR_DEC  = 5'd15,
    KIND_ERR_EXP  = 5'd16,
    KIND_ERR_CHAR = 5'd17
  } token_kind_e;

  typedef enum logic [3:0] {
    ST_START    = 4'd0,
    ST_VAR      = 4'd1,
    ST_INT      = 4'd2,
    ST_DEC      = 4'd3,
    ST_EXP      = 4'd4,
    ST_EXP_SIGN = 4'd5,
    ST_EXP_DIG  = 4'd6,
    ST_SLASH    = 4'd14,
    ST_COMMENT  = 4'd15
  } dfa_state_e;

  typedef struct packed {
    logic        letter;
    logic        digit;
    logic        blank;
    logic        newline;
    logic        op;
    token_kind_e op_kind;
    logic        slash;
    logic        underscore;
    logic        dot;
    logic        e_char;
    logic        minus;
    logic        delim;
    logic        alpha;
  } char_class_t;

  typedef struct packed {
    dfa_state_e  dfa;
    logic        err;
    logic        inv;
    logic        fcf;
    logic [9:0]  len;
  } lex_state_t;

  typedef struct packed {
    lex_state_t  st;
    logic        done;
    logic        emit;
    token_kind_e kind;
    logic [9:0]  elen;
  } step_t;

  typedef struct packed {
    token_kind_e kind;
    logic [9:0]  length;
    logic        last;
  } token_t;

  typedef struct packed {
    logic [1:0]  n;
    token_t      tok0;
    token_t      tok1;
  } tok_batch_t;

  function automatic char_class_t ael_classify(logic [7:0] c);
    char_class_t cl;
    cl.letter     = ((c >= CH_LO_A) && (c <= CH_LO_Z)) || ((c >= CH_UP_A) && (c <= CH_UP_Z));
    cl.digit      = (c >= CH_ZERO) && (c <= CH_NINE);
    cl.newline    = (c == CH_LF);
    cl.blank      = (c == CH_LF) || (c == CH_TAB) || (c == CH_SPACE);
    cl.slash      = (c == CH_SLASH);
    cl.underscore = (c == CH_UNDER);
    cl.dot        = (c == CH_DOT);
    cl.e_char     = (c == CH_LO_E) || (c == CH_UP_E);
    cl.minus      = (c == CH_MINUS);
    cl.op         = 1'b1;
    unique case (c)
      CH_PLUS:   cl.op_kind = KIND_PLUS;
      CH_MINUS:  cl.op_kind = KIND_MINUS;
      CH_STAR:   cl.op_kind = KIND_STAR;
      CH_CARET:  cl.op_kind = KIND_CARET;
      CH_LPAREN: cl.op_kind = KIND_LPAREN;
      CH_RPAREN: cl.op_kind = KIND_RPAREN;
      CH_EQUAL:  cl.op_kind = KIND_EQUAL;
      CH_SLASH:  cl.op_kind = KIND_SLASH;
      default: begin
        cl.op      = 1'b0;
        cl.op_kind = KIND_VAR;
      end
    endcase
    cl.delim = cl.op || cl.blank;
    cl.alpha = cl.letter || cl.digit || cl.delim || cl.underscore || cl.dot;
    return cl;
  endfunction

  function automatic logic [9:0] ael_gather(logic [9:0] len, logic [9:0] cap);
    return (len < cap) ? len + 10'd1 : len;
  endfunction

  // One pass of the lexer rule for the current character.
  function automatic step_t ael_step(char_class_t cl, lex_state_t st_in, logic [9:0] cap);
    step_t      r;
    lex_state_t s;
    logic       done;
    s      = st_in;
    done   = 1'b0;
    r.emit = 1'b0;
    r.kind = KIND_VAR;
    r.elen = '0;
    if (!cl.alpha) begin
      s.inv = 1'b1;
      s.err = 1'b1;
      done  = 1'b1;
    end
    if ((s.inv || s.err) && cl.delim && (s.dfa != ST_COMMENT)) begin
      // Close a malformed token.
      r.emit = 1'b1;
      r.elen = s.len;
      if (s.inv) begin
        r.kind = KIND_ERR_CHAR;
      end else begin
        unique case (s.dfa)
          ST_START: r.kind = KIND_ERR_INIT;
          ST_VAR:   r.kind = KIND_ERR_VAR;
          ST_INT:   r.kind = KIND_ERR_INT;
          ST_DEC:   r.kind = KIND_ERR_DEC;
          default:  r.kind = KIND_ERR_EXP;
        endcase
      end
      s.len = '0;
      s.dfa = ST_START;
      s.inv = 1'b0;
      s.err = 1'b0;
    end else begin
      unique case (s.dfa)
        ST_START: begin
          if (cl.blank) begin
            done = 1'b1;
          end else if (!(cl.letter || cl.digit || cl.op)) begin
            s.len = ael_gather(s.len, cap);
            s.err = 1'b1;
            done  = 1'b1;
          end else if (cl.slash) begin
            s.dfa = ST_SLASH;
            s.fcf = 1'b1;
          end else if (cl.digit) begin
            s.dfa = ST_INT;
            s.fcf = 1'b1;
          end else if (cl.op) begin
            r.emit = 1'b1;
            r.kind = cl.op_kind;
            r.elen = 10'd1;
            s.len  = '0;
            done   = 1'b1;
          end else begin
            s.dfa = ST_VAR;
            s.fcf = 1'b1;
          end
        end
        ST_VAR: begin
          if (cl.letter || cl.digit || cl.underscore) begin
            s.len = ael_gather(s.len, cap);
            done  = 1'b1;
          end else if (cl.delim) begin
            r.emit = 1'b1;
            r.kind = KIND_VAR;
            r.elen = s.len;
            s.len  = '0;
            s.dfa  = ST_START;
          end else begin
            s.len = ael_gather(s.len, cap);
            s.err = 1'b1;
            done  = 1'b1;
          end
        end
        ST_INT: begin
          if (cl.digit || cl.dot) begin
            s.len = ael_gather(s.len, cap);
            done  = 1'b1;
            if (cl.dot && !s.err) begin
              s.dfa = ST_DEC;
              s.fcf = 1'b1;
            end
          end else if (cl.delim) begin
            r.emit = 1'b1;
            r.kind = KIND_INT;
            r.elen = s.len;
            s.len  = '0;
            s.dfa  = ST_START;
          end else begin
            s.len = ael_gather(s.len, cap);
            s.err = 1'b1;
            done  = 1'b1;
          end
        end
        ST_DEC: begin
          if (cl.digit || cl.e_char) begin
            s.len = ael_gather(s.len, cap);
            done  = 1'b1;
            if (cl.e_char && !s.err) begin
              if (s.fcf) begin
                s.err = 1'b1;
              end else begin
                s.dfa = ST_EXP;
              end
            end
          end else if (cl.delim) begin
            r.emit = 1'b1;
            r.kind = KIND_REAL;
            r.elen = s.len;
            s.len  = '0;
            s.dfa  = ST_START;
          end else begin
            s.len = ael_gather(s.len, cap);
            s.err = 1'b1;
            done  = 1'b1;
          end
          s.fcf = 1'b0;
        end
        ST_EXP: begin
          if ((cl.digit || cl.minus) && !s.err) begin
            s.len = ael_gather(s.len, cap);
            done  = 1'b1;
            s.dfa = cl.minus ? ST_EXP_SIGN : ST_EXP_DIG;
          end else if (cl.delim) begin
            s.err = 1'b1;
          end else begin
            s.len = ael_gather(s.len, cap);
            s.err = 1'b1;
            done  = 1'b1;
          end
        end
        ST_EXP_SIGN: begin
          if (cl.digit) begin
            s.len = ael_gather(s.len, cap);
            s.dfa = ST_EXP_DIG;
            done  = 1'b1;
          end else if (cl.delim) begin
            s.err = 1'b1;
          end else begin
            s.len = ael_gather(s.len, cap);
            s.err = 1'b1;
            done  = 1'b1;
          end
        end
        ST_EXP_DIG: begin
          if (cl.digit) begin
            s.len = ael_gather(s.len, cap);
            done  = 1'b1;
          end else if (cl.delim) begin
            r.emit = 1'b1;
            r.kind = KIND_REAL;
            r.elen = s.len;
            s.len  = '0;
            s.dfa  = ST_START;
          end else begin
            s.len = ael_gather(s.len, cap);
            s.err = 1'b1;
            done  = 1'b1;
          end
        end
        ST_SLASH: begin
          if (cl.slash) begin
            s.len = ael_gather(s.len, cap);
            done  = 1'b1;
            if (!s.fcf) begin
              s.dfa = ST_COMMENT;
            end
          end else begin
            r.emit = 1'b1;
            r.kind = KIND_SLASH;
            r.elen = 10'd1;
            s.len  = '0;
            s.dfa  = ST_START;
          end
          s.fcf = 1'b0;
        end
        ST_COMMENT: begin
          if (cl.newline) begin
            r.emit = 1'b1;
            r.kind = KIND_COMMENT;
            r.elen = s.len;
            s.len  = '0;
            s.dfa  = ST_START;
          end else begin
            s.len = ael_gather(s.len, cap);
          end
          done = 1'b1;
        end
        default: begin
          s.dfa = ST_START;
        end
      endcase
    end
    r.st   = s;
    r.done = done;
    return r;
  endfunction

endpackage

// ----- design/ael_front.sv -----
// Front end: accept bytes, classify them and hold the classes in a two-entry queue.
module ael_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  logic [7:0]           char_byte_i,
  output logic                 full_o,
  output logic                 cls_valid_o,
  output ael_pkg::char_class_t cls_o,
  input  logic                 cls_pop_i
);

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);

  ael_pkg::char_class_t    mem_q [Depth];
  logic [PtrW-1:0]         wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]         rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]           count_q, count_d;
  logic                    wr_en, rd_en;

  assign full_o      = (count_q == (PtrW+1)'(Depth));
  assign cls_valid_o = (count_q != '0);
  assign cls_o       = mem_q[rd_ptr_q];
  assign wr_en       = push_i && !full_o;
  assign rd_en       = cls_pop_i && cls_valid_o;

  always_comb begin
    wr_ptr_d = wr_en ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = rd_en ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + (PtrW+1)'(wr_en) - (PtrW+1)'(rd_en);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= ael_pkg::ael_classify(char_byte_i);
    end
  end

endmodule

// ----- design/ael_back.sv -----
// Back end: the lexer state and the per-byte token rule.
module ael_back #(
  parameter logic [9:0] LEN_CAP = 10'd1023
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cls_valid_i,
  input  ael_pkg::char_class_t cls_i,
  output logic                 cls_pop_o,
  input  logic                 room_i,
  output ael_pkg::tok_batch_t  batch_o
);

  ael_pkg::lex_state_t state_q, state_d;
  logic                take;

  assign take      = cls_valid_i && room_i;
  assign cls_pop_o = take;

  // A byte needs at most four passes of the rule; passes after the final one hold.
  always_comb begin
    ael_pkg::lex_state_t st [5];
    logic                done [5];
    ael_pkg::step_t      r [4];
    ael_pkg::tok_batch_t b;
    st[0]   = state_q;
    done[0] = 1'b0;
    b       = '0;
    for (int i = 0; i < 4; i++) begin
      r[i] = ael_pkg::ael_step(cls_i, st[i], LEN_CAP);
      if (!done[i]) begin
        st[i+1]   = r[i].st;
        done[i+1] = r[i].done;
        if (r[i].emit) begin
          if (b.n == 2'd0) begin
            b.tok0.kind   = r[i].kind;
            b.tok0.length = r[i].elen;
          end else begin
            b.tok1.kind   = r[i].kind;
            b.tok1.length = r[i].elen;
          end
          b.n = b.n + 2'd1;
        end
      end else begin
        st[i+1]   = st[i];
        done[i+1] = 1'b1;
      end
    end
    // A newline always returns to the start of a line.
    if (cls_i.newline) begin
      st[4].dfa = ael_pkg::ST_START;
      st[4].fcf = 1'b1;
    end
    b.tok0.last = (b.n == 2'd1);
    b.tok1.last = (b.n == 2'd2);
    if (!take) begin
      b.n = 2'd0;
    end
    batch_o = b;
    state_d = take ? st[4] : state_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.dfa <= ael_pkg::ST_START;
      state_q.err <= 1'b0;
      state_q.inv <= 1'b0;
      state_q.fcf <= 1'b1;
      state_q.len <= '0;
    end else begin
      state_q <= state_d;
    end
  end

  a_len_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.len <= LEN_CAP)
    else $error("gathered length above cap");

  a_newline_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && cls_i.newline) |=> (state_q.dfa == ael_pkg::ST_START) && state_q.fcf)
    else $error("newline did not return to start");

  a_comment_on_newline: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((batch_o.n != 2'd0) && (batch_o.tok0.kind == ael_pkg::KIND_COMMENT)) |-> cls_i.newline)
    else $error("comment closed without newline");

endmodule

// ----- design/ael_token_fifo.sv -----
// Result queue: up to two tokens written per cycle, one read per cycle.
module ael_token_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ael_pkg::tok_batch_t batch_i,
  output logic                room_o,
  output logic                empty_o,
  input  logic                pop_i,
  output ael_pkg::token_t     head_o
);

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);

  ael_pkg::token_t  mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]    count_q, count_d;
  logic             rd_en;

  assign empty_o = (count_q == '0);
  assign room_o  = (count_q <= (PtrW+1)'(Depth - 2));
  assign head_o  = mem_q[rd_ptr_q];
  assign rd_en   = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q + PtrW'(batch_i.n);
    rd_ptr_d = rd_en ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + (PtrW+1)'(batch_i.n) - (PtrW+1)'(rd_en);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (batch_i.n != 2'd0) begin
      mem_q[wr_ptr_q] <= batch_i.tok0;
    end
    if (batch_i.n == 2'd2) begin
      mem_q[wr_ptr_q + 1'b1] <= batch_i.tok1;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (batch_i.n != 2'd0) |-> ((4'(count_q) + 4'(batch_i.n)) <= 4'(Depth)))
    else $error("token queue overflow");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (PtrW+1)'(Depth))
    else $error("token count out of range");

endmodule

// ----- design/arithmetic_expression_lexer_core.sv -----
// Top level of the arithmetic expression lexer.
//
// Usage: write one ASCII byte per transfer on the input queue (push, full,
// char_byte_i). Read tokens from the result queue (empty, pop and the
// token_* ports); the oldest token sits on the ports while empty is low.
// Each byte yields zero, one or two tokens; last_in_run_o marks the final
// token of a byte. A newline ends the line and restarts the lexer.
//
// An accepted byte is classified into the class queue; the back end then
// writes its tokens into the token queue. Throughput: one byte per cycle
// while the token queue has room, as the back-end rule is combinational;
// a byte that yields two tokens needs two pops to drain.
//
// Reset clears both queues and puts the lexer in its start state with the
// first-character flag set. When the reader stalls, the four-entry token
// queue fills; once fewer than two slots are free the back end holds, the
// two-entry class queue fills and full rises.
module arithmetic_expression_lexer_core #(
  parameter int unsigned MAX_TOKEN_LENGTH = 1023
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] char_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic [4:0] token_kind_o,
  output logic [9:0] token_length_o,
  output logic       last_in_run_o
);

  // Lengths saturate at the parameter, never above what the port can show.
  localparam logic [9:0] LenCap =
    (MAX_TOKEN_LENGTH > 1023) ? 10'd1023 : 10'(MAX_TOKEN_LENGTH);

  logic                 cls_valid;
  logic                 cls_pop;
  ael_pkg::char_class_t cls;
  logic                 room;
  ael_pkg::tok_batch_t  batch;
  ael_pkg::token_t      head;

  // Front: accept and classify bytes.
  ael_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .char_byte_i (char_byte_i),
    .full_o      (full),
    .cls_valid_o (cls_valid),
    .cls_o       (cls),
    .cls_pop_i   (cls_pop)
  );

  // Back: advance the lexer one byte per cycle while the token queue has room.
  ael_back #(
    .LEN_CAP (LenCap)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cls_valid_i (cls_valid),
    .cls_i       (cls),
    .cls_pop_o   (cls_pop),
    .room_i      (room),
    .batch_o     (batch)
  );

  // Hold finished tokens until the reader takes them.
  ael_token_fifo u_tok_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .batch_i (batch),
    .room_o  (room),
    .empty_o (empty),
    .pop_i   (pop),
    .head_o  (head)
  );

  assign token_kind_o   = head.kind;
  assign token_length_o = head.length;
  assign last_in_run_o  = head.last;

endmodule
